// File: rtl/slps_pkg.sv
package slps_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_MODE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Mode codes
    localparam logic [3:0] MODE_OFF         = 4'd0;
    localparam logic [3:0] MODE_GREEN       = 4'd1;
    localparam logic [3:0] MODE_RED         = 4'd2;
    localparam logic [3:0] MODE_AMBER       = 4'd3;
    localparam logic [3:0] MODE_AMBER_FAST  = 4'd4;
    localparam logic [3:0] MODE_RED_FAST    = 4'd5;
    localparam logic [3:0] MODE_RED_BLINK   = 4'd6;
    localparam logic [3:0] MODE_GREEN_BURST = 4'd7;
    localparam logic [3:0] MODE_RED_BURST   = 4'd8;
    localparam logic [3:0] MODE_RED_BURST5  = 4'd9;
    localparam logic [3:0] MODE_MAX         = MODE_RED_BURST5;

    // Thermal blanking: the tick that finds the count here blanks the LEDs
    localparam logic [3:0] THERMAL_LIMIT = 4'd12;

    // Phase timer: bit 7 is the blink phase, bits 6..0 a counter
    localparam logic [7:0] PHASE_BIT      = 8'h80;
    localparam logic [7:0] COUNT_MASK     = 8'h7F;
    localparam logic [6:0] RED_BLINK_HOLD = 7'd3;
    localparam logic [6:0] BURST3_LIMIT   = 7'd6;
    localparam logic [6:0] BURST5_LIMIT   = 7'd10;

    // Architectural state of the sequencer
    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] phase;
        logic [3:0] thermal_count;
        logic       red;
        logic       green;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:          MODE_OFF,
        phase:         8'h00,
        thermal_count: 4'd0,
        red:           1'b0,
        green:         1'b0
    };

endpackage

// File: rtl/status_led_pattern_sequencer_core.sv
// Status LED pattern sequencer core.
// Input channel (i_valid / o_ready) carries one command item: tick, set mode
// or clear, with the thermal step-down flag and the new mode. Output channel
// (o_valid / i_ready) returns exactly one result item per command: the red
// and green LED levels and the mode after that command.
// An accepted item is held in an input register; when the result register is
// free or its item is being taken, the step logic updates the state and loads
// the result register, whose valid flag drives o_valid.
// Throughput is one item per cycle while the receiver keeps i_ready high: the
// input register refills in the same cycle it hands on its item, and the
// result register is the only thing gating it.
// When the receiver stalls, the result register holds its item and the
// input register holds one more; o_ready then drops until i_ready returns.
// Reset clears both valid flags and puts the state to mode off, timers zero
// and both LEDs low.
module status_led_pattern_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic       i_thermal_step_down,
    input  logic [3:0] i_new_mode,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_red_led,
    output logic       o_green_led,
    output logic [3:0] o_current_mode
);

    logic             r_in_valid;
    logic [1:0]       r_command;
    logic             r_thermal;
    logic [3:0]       r_new_mode;
    slps_pkg::t_state r_state;
    slps_pkg::t_state n_state;
    logic             r_out_valid;
    logic             r_red;
    logic             r_green;
    logic [3:0]       r_mode;
    logic             advance;

    // item moves from input register to result register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_command  <= i_command;
            r_thermal  <= i_thermal_step_down;
            r_new_mode <= i_new_mode;
        end
    end

    // Next-state logic
    slps_step u_step (
        .i_state             (r_state),
        .i_command           (r_command),
        .i_thermal_step_down (r_thermal),
        .i_new_mode          (r_new_mode),
        .o_state             (n_state)
    );

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slps_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_red   <= n_state.red;
            r_green <= n_state.green;
            r_mode  <= n_state.mode;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_led      = r_red;
    assign o_green_led    = r_green;
    assign o_current_mode = r_mode;

endmodule

// File: rtl/slps_step.sv
module slps_step (
    input  slps_pkg::t_state i_state,
    input  logic [1:0]       i_command,
    input  logic             i_thermal_step_down,
    input  logic [3:0]       i_new_mode,
    output slps_pkg::t_state o_state
);

    slps_pkg::t_state s_tick;
    logic [6:0]       cnt;
    logic [6:0]       burst_limit;
    logic [6:0]       blink_limit;
    logic             phase_on;

    assign cnt         = i_state.phase[6:0];
    assign phase_on    = i_state.phase[7];
    assign burst_limit = (i_state.mode == slps_pkg::MODE_RED_BURST5) ?
                         slps_pkg::BURST5_LIMIT : slps_pkg::BURST3_LIMIT;
    assign blink_limit = (i_state.mode == slps_pkg::MODE_RED_BLINK) ?
                         slps_pkg::RED_BLINK_HOLD : 7'd0;

    // One tick step of the pattern
    always_comb begin
        s_tick = i_state;
        if (i_thermal_step_down && (i_state.thermal_count >= slps_pkg::THERMAL_LIMIT)) begin
            // blanking tick: pattern does not step
            s_tick.thermal_count = 4'd0;
            s_tick.red           = 1'b0;
            s_tick.green         = 1'b0;
        end else begin
            s_tick.thermal_count = i_thermal_step_down ?
                                   (i_state.thermal_count + 4'd1) : 4'd0;
            case (i_state.mode)
                slps_pkg::MODE_OFF: begin
                    s_tick.red   = 1'b0;
                    s_tick.green = 1'b0;
                    s_tick.phase = 8'h00;
                end
                slps_pkg::MODE_GREEN: begin
                    s_tick.red   = 1'b0;
                    s_tick.green = 1'b1;
                end
                slps_pkg::MODE_RED: begin
                    s_tick.red   = 1'b1;
                    s_tick.green = 1'b0;
                end
                slps_pkg::MODE_AMBER: begin
                    s_tick.red   = 1'b1;
                    s_tick.green = 1'b1;
                end
                slps_pkg::MODE_AMBER_FAST: begin
                    s_tick.phase = phase_on ? 8'h00 : slps_pkg::PHASE_BIT;
                    s_tick.red   = !phase_on;
                    s_tick.green = !phase_on;
                end
                slps_pkg::MODE_RED_FAST, slps_pkg::MODE_RED_BLINK: begin
                    s_tick.green = 1'b0;
                    if (cnt < blink_limit) begin
                        s_tick.phase = {phase_on, cnt + 7'd1};
                        s_tick.red   = phase_on;
                    end else begin
                        s_tick.phase = phase_on ? 8'h00 : slps_pkg::PHASE_BIT;
                        s_tick.red   = !phase_on;
                    end
                end
                slps_pkg::MODE_GREEN_BURST, slps_pkg::MODE_RED_BURST,
                slps_pkg::MODE_RED_BURST5: begin
                    if (cnt > burst_limit) begin
                        // burst done: fall back to off, LEDs hold
                        s_tick.phase = i_state.phase & slps_pkg::COUNT_MASK;
                        s_tick.mode  = slps_pkg::MODE_OFF;
                    end else begin
                        s_tick.phase = {1'b0, cnt + 7'd1};
                        if (cnt[0]) begin
                            if (i_state.mode == slps_pkg::MODE_GREEN_BURST) begin
                                s_tick.green = 1'b1;
                            end else begin
                                s_tick.red = 1'b1;
                            end
                        end else begin
                            s_tick.red   = 1'b0;
                            s_tick.green = 1'b0;
                        end
                    end
                end
                default: begin
                    s_tick.thermal_count = s_tick.thermal_count;
                end
            endcase
        end
    end

    // Command decode
    always_comb begin
        o_state = i_state;
        unique case (i_command)
            slps_pkg::CMD_TICK: begin
                o_state = s_tick;
            end
            slps_pkg::CMD_SET_MODE: begin
                if (i_new_mode <= slps_pkg::MODE_MAX) begin
                    o_state.mode = i_new_mode;
                end
            end
            slps_pkg::CMD_CLEAR: begin
                o_state = slps_pkg::STATE_RESET;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
